// ===== hdl/clsr_pkg.sv =====
// Package for the cubic/linear sample resampler: widths, opcodes, register indexes
// and the shared structs passed between the front end, queue and back end.
// No dependencies.
`timescale 1ns / 1ps
package clsr_pkg;

    localparam int STORE_DEPTH = 1024;
    localparam int ADDR_BITS   = 10;
    localparam int SAMPLE_BITS = 16;
    localparam int FRAC_BITS   = 16;
    localparam int SCOUNT_BITS = 11;
    localparam int DCOUNT_BITS = 16;
    localparam int NUM_BITS    = SCOUNT_BITS + DCOUNT_BITS;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_BITS   = 2;

    localparam logic OP_WRITE   = 1'b0;
    localparam logic OP_COMPUTE = 1'b1;

    localparam logic [1:0] REG_INTERP_MODE  = 2'd0;
    localparam logic [1:0] REG_SOURCE_COUNT = 2'd1;
    localparam logic [1:0] REG_DEST_COUNT   = 2'd2;

    // Item kinds handed from the front end to the back end.
    typedef enum logic [1:0] {
        KIND_WRITE,
        KIND_ERROR,
        KIND_SINGLE,
        KIND_INTERP
    } item_kind_t;

    typedef struct packed {
        item_kind_t             kind;
        logic [ADDR_BITS-1:0]   addr;
        logic [SAMPLE_BITS-1:0] sample;
        logic [NUM_BITS-1:0]    num;
    } front_item_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_READ,
        ST_MATH
    } back_state_t;

endpackage

// ===== hdl/clsr_front.sv =====
// Front end: accepts input transactions, classifies them and computes the
// position numerator out_index*(S-1). Depends on clsr_pkg.
`timescale 1ns / 1ps
module clsr_front
    import clsr_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic                   opcode,
    input  logic [ADDR_BITS-1:0]   write_address,
    input  logic [SAMPLE_BITS-1:0] write_sample,
    input  logic [DCOUNT_BITS-1:0] out_index,
    input  logic [SCOUNT_BITS-1:0] s_eff,
    input  logic [DCOUNT_BITS-1:0] dest_count,
    output logic                   item_valid,
    input  logic                   item_ready,
    output front_item_t            item
);

    logic        valid_reg;
    front_item_t item_reg;
    front_item_t item_next;

    assign in_ready   = !valid_reg || item_ready;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    // Classify the item and form the numerator.
    always_comb
    begin
        item_next.addr   = write_address;
        item_next.sample = write_sample;
        item_next.num    = NUM_BITS'(out_index) * NUM_BITS'(s_eff - SCOUNT_BITS'(1));
        if (opcode == OP_WRITE)
            item_next.kind = KIND_WRITE;
        else if (s_eff == '0 || dest_count == '0 || out_index >= dest_count)
            item_next.kind = KIND_ERROR;
        else if (s_eff == SCOUNT_BITS'(1) || dest_count == DCOUNT_BITS'(1))
            item_next.kind = KIND_SINGLE;
        else
            item_next.kind = KIND_INTERP;
    end

    // Output register of the front end.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            item_reg <= item_next;
    end

endmodule

// ===== hdl/clsr_queue.sv =====
// Short FIFO between the front end and the back end.
// Depends on clsr_pkg.
`timescale 1ns / 1ps
module clsr_queue
    import clsr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        wr_valid,
    output logic        wr_ready,
    input  front_item_t wr_item,
    output logic        rd_valid,
    input  logic        rd_ready,
    output front_item_t rd_item
);

    front_item_t            mem_reg [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0]   wptr_reg;
    logic [QPTR_BITS-1:0]   rptr_reg;
    logic [QPTR_BITS:0]     count_reg;
    logic                   push;
    logic                   pop;

    assign wr_ready = count_reg != (QPTR_BITS+1)'(QUEUE_DEPTH);
    assign rd_valid = count_reg != '0;
    assign rd_item  = mem_reg[rptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    // Pointer and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push)
                wptr_reg <= wptr_reg + QPTR_BITS'(1);
            if (pop)
                rptr_reg <= rptr_reg + QPTR_BITS'(1);
            if (push && !pop)
                count_reg <= count_reg + (QPTR_BITS+1)'(1);
            else if (pop && !push)
                count_reg <= count_reg - (QPTR_BITS+1)'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wptr_reg] <= wr_item;
    end

endmodule

// ===== hdl/clsr_back.sv =====
// Back end: restoring divider for index and fraction, four reads of the sample
// store, interpolation arithmetic and the output register. Depends on clsr_pkg.
`timescale 1ns / 1ps
module clsr_back
    import clsr_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   item_valid,
    output logic                   item_ready,
    input  front_item_t            item,
    input  logic                   interp_mode,
    input  logic [SCOUNT_BITS-1:0] s_eff,
    input  logic [DCOUNT_BITS-1:0] dest_count,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [SAMPLE_BITS-1:0] out_sample,
    output logic                   status
);

    localparam int QBITS = NUM_BITS + FRAC_BITS;
    localparam int WBITS = SAMPLE_BITS + 4;
    localparam int PBITS = WBITS + FRAC_BITS + 2;

    logic [SAMPLE_BITS-1:0] store_mem [STORE_DEPTH];
    logic [SAMPLE_BITS-1:0] rd_data_reg;

    back_state_t            state_reg;
    back_state_t            state_next;
    logic [5:0]             cnt_reg;
    logic [DCOUNT_BITS:0]   rem_reg;
    logic [QBITS-1:0]       quo_reg;
    logic [DCOUNT_BITS-1:0] divisor;
    logic [DCOUNT_BITS+1:0] trial;
    logic [ADDR_BITS-1:0]   rd_addr;
    logic [ADDR_BITS:0]     idx;
    logic [ADDR_BITS:0]     last;
    logic [ADDR_BITS:0]     nb;
    logic [1:0]             tap_sel;
    logic signed [SAMPLE_BITS-1:0] y_reg [4];
    logic signed [FRAC_BITS:0]     f;
    logic signed [WBITS-1:0]  acc_reg;
    logic signed [PBITS-1:0]  prod;
    logic signed [PBITS-1:0]  shifted;
    logic signed [WBITS-1:0]  a2;
    logic signed [WBITS-1:0]  b2;
    logic signed [WBITS-1:0]  c2;
    logic signed [WBITS-1:0]  lin_d;
    logic signed [WBITS-1:0]  y1w;
    logic signed [WBITS-1:0]  res;
    logic                     oval_reg;
    logic [SAMPLE_BITS-1:0]   osample_reg;
    logic                     ostatus_reg;
    logic                     start;
    logic                     finish;
    logic                     out_free;
    logic [SAMPLE_BITS-1:0]   fin_sample;
    logic                     fin_status;

    assign out_valid  = oval_reg;
    assign out_sample = osample_reg;
    assign status     = ostatus_reg;
    assign out_free   = !oval_reg || out_ready;
    assign divisor    = dest_count - DCOUNT_BITS'(1);
    assign last       = (ADDR_BITS+1)'(s_eff - SCOUNT_BITS'(1));
    assign idx        = quo_reg[FRAC_BITS +: ADDR_BITS+1];
    assign f          = {1'b0, quo_reg[FRAC_BITS-1:0]};
    assign item_ready = (state_reg == ST_IDLE) && out_free;
    assign start      = item_ready && item_valid;
    assign trial      = {rem_reg, quo_reg[QBITS-1]} - {2'b00, divisor};

    // Neighbor addresses, clamped at both ends.
    always_comb
    begin
        tap_sel = cnt_reg[1:0];
        case (tap_sel)
            2'd0:    nb = (idx == '0) ? '0 : idx - (ADDR_BITS+1)'(1);
            2'd1:    nb = idx;
            2'd2:    nb = (idx + (ADDR_BITS+1)'(1) < last) ? idx + (ADDR_BITS+1)'(1) : last;
            default: nb = (idx + (ADDR_BITS+1)'(2) < last) ? idx + (ADDR_BITS+1)'(2) : last;
        endcase
        if (state_reg == ST_IDLE)
            rd_addr = '0;
        else
            rd_addr = nb[ADDR_BITS-1:0];
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start && item.kind == KIND_INTERP)
                    state_next = ST_DIV;
                else if (start && item.kind == KIND_SINGLE)
                    state_next = ST_MATH;
            end
            ST_DIV:
            begin
                if (cnt_reg == 6'(QBITS - 1))
                    state_next = ST_READ;
            end
            ST_READ:
            begin
                if (cnt_reg == 6'd4)
                    state_next = ST_MATH;
            end
            ST_MATH:
            begin
                if ((cnt_reg == 6'd5 || finish) && out_free)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Arithmetic: linear in one step; cubic in three Horner steps over cnt.
    always_comb
    begin
        y1w   = WBITS'(y_reg[1]);
        a2    = -WBITS'(y_reg[0]) + WBITS'(3) * y1w - WBITS'(3) * WBITS'(y_reg[2])
                + WBITS'(y_reg[3]);
        b2    = WBITS'(2) * WBITS'(y_reg[0]) - WBITS'(5) * y1w
                + WBITS'(4) * WBITS'(y_reg[2]) - WBITS'(y_reg[3]);
        c2    = WBITS'(y_reg[2]) - WBITS'(y_reg[0]);
        lin_d = WBITS'(y_reg[2]) - y1w;
        prod  = PBITS'(acc_reg) * PBITS'(f);
        if (interp_mode == 1'b0)
            shifted = (PBITS'(lin_d) * PBITS'(f) + PBITS'(1 << (FRAC_BITS - 1))) >>> FRAC_BITS;
        else if (cnt_reg == 6'd3)
            shifted = (prod + PBITS'(1 << FRAC_BITS)) >>> (FRAC_BITS + 1);
        else
            shifted = prod >>> FRAC_BITS;
        res = y1w + WBITS'(shifted);
        if (res > WBITS'(32767))
            fin_sample = 16'h7FFF;
        else if (res < -WBITS'(32768))
            fin_sample = 16'h8000;
        else
            fin_sample = res[SAMPLE_BITS-1:0];
        fin_status = 1'b0;
    end

    // The last arithmetic step of an interpolated item; single-sample items never get here.
    assign finish = (state_reg == ST_MATH) && (cnt_reg != 6'd5)
                    && (interp_mode == 1'b0 || cnt_reg == 6'd3);

    // Sample store, one write port and one read port.
    always_ff @(posedge clk)
    begin
        if (start && item.kind == KIND_WRITE)
            store_mem[item.addr] <= item.sample;
        rd_data_reg <= store_mem[rd_addr];
    end

    // Control and datapath registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            oval_reg  <= 1'b0;
        end
        else
        begin
            if (oval_reg && out_ready)
                oval_reg <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    cnt_reg <= '0;
                    if (start && (item.kind == KIND_WRITE || item.kind == KIND_ERROR))
                        oval_reg <= 1'b1;
                    if (start && item.kind == KIND_SINGLE)
                        cnt_reg <= 6'd5;
                end
                ST_DIV:  cnt_reg <= (cnt_reg == 6'(QBITS - 1)) ? '0 : cnt_reg + 6'd1;
                ST_READ: cnt_reg <= (cnt_reg == 6'd4) ? '0 : cnt_reg + 6'd1;
                ST_MATH:
                begin
                    if (cnt_reg == 6'd5)
                    begin
                        if (out_free)
                            oval_reg <= 1'b1;
                    end
                    else if (interp_mode == 1'b0 || cnt_reg == 6'd3)
                    begin
                        if (out_free)
                        begin
                            oval_reg <= 1'b1;
                            cnt_reg  <= '0;
                        end
                    end
                    else
                        cnt_reg <= cnt_reg + 6'd1;
                end
                default: cnt_reg <= '0;
            endcase
            state_reg <= state_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= {item.num, {FRAC_BITS{1'b0}}};
            if (item.kind == KIND_WRITE || item.kind == KIND_ERROR)
            begin
                osample_reg <= '0;
                ostatus_reg <= (item.kind == KIND_ERROR);
            end
        end
        else if (state_reg == ST_DIV)
        begin
            if (!trial[DCOUNT_BITS+1])
            begin
                rem_reg <= trial[DCOUNT_BITS:0];
                quo_reg <= {quo_reg[QBITS-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= {rem_reg[DCOUNT_BITS-1:0], quo_reg[QBITS-1]};
                quo_reg <= {quo_reg[QBITS-2:0], 1'b0};
            end
        end
        if (state_reg == ST_READ && cnt_reg != '0)
            y_reg[cnt_reg[1:0] - 2'd1] <= rd_data_reg;
        if (state_reg == ST_MATH)
        begin
            if (cnt_reg == 6'd5)
            begin
                osample_reg <= rd_data_reg;
                ostatus_reg <= 1'b0;
            end
            else if (cnt_reg == 6'd0)
                acc_reg <= a2;
            else if (cnt_reg == 6'd1)
                acc_reg <= WBITS'(shifted) + b2;
            else if (cnt_reg == 6'd2)
                acc_reg <= WBITS'(shifted) + c2;
            if (finish && out_free)
            begin
                osample_reg <= fin_sample;
                ostatus_reg <= fin_status;
            end
        end
    end

endmodule

// ===== hdl/cubic_linear_sample_resampler.sv =====
// Catmull-Rom / linear sample resampler, top level.
// Interpolated items pass through the 43-step divider, four store reads and 1 (linear)
// or 4 (cubic) math steps; writes and errors go straight to the output register.
// Throughput: writes and errors one per cycle while the output is not stalled; the back end
// takes no new item until a single-sample or interpolated item has reached the output.
// Reset (rst_n, async, active low) clears control state; mode cubic, counts zero.
`timescale 1ns / 1ps
module cubic_linear_sample_resampler
    import clsr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // write_address[9:0], write_sample[25:10], out_index[41:26]
    input  logic        s_axis_tuser,   // opcode
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // out_sample[15:0]
    output logic        m_axis_tuser,   // status
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    logic                   interp_mode_reg;
    logic [SCOUNT_BITS-1:0] source_count_reg;
    logic [DCOUNT_BITS-1:0] dest_count_reg;
    logic [SCOUNT_BITS-1:0] s_eff;
    logic                   f_valid;
    logic                   f_ready;
    front_item_t            f_item;
    logic                   q_valid;
    logic                   q_ready;
    front_item_t            q_item;

    assign cfg_ready = 1'b1;
    assign s_eff = (source_count_reg > SCOUNT_BITS'(STORE_DEPTH)) ?
                   SCOUNT_BITS'(STORE_DEPTH) : source_count_reg;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            interp_mode_reg  <= 1'b1;
            source_count_reg <= '0;
            dest_count_reg   <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_INTERP_MODE:  interp_mode_reg  <= cfg_data[0];
                REG_SOURCE_COUNT: source_count_reg <= cfg_data[SCOUNT_BITS-1:0];
                REG_DEST_COUNT:   dest_count_reg   <= cfg_data;
                default:          ;
            endcase
        end
    end

    clsr_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (s_axis_tvalid),
        .in_ready      (s_axis_tready),
        .opcode        (s_axis_tuser),
        .write_address (s_axis_tdata[9:0]),
        .write_sample  (s_axis_tdata[25:10]),
        .out_index     (s_axis_tdata[41:26]),
        .s_eff         (s_eff),
        .dest_count    (dest_count_reg),
        .item_valid    (f_valid),
        .item_ready    (f_ready),
        .item          (f_item)
    );

    clsr_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (f_valid),
        .wr_ready (f_ready),
        .wr_item  (f_item),
        .rd_valid (q_valid),
        .rd_ready (q_ready),
        .rd_item  (q_item)
    );

    clsr_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (q_valid),
        .item_ready  (q_ready),
        .item        (q_item),
        .interp_mode (interp_mode_reg),
        .s_eff       (s_eff),
        .dest_count  (dest_count_reg),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .out_sample  (m_axis_tdata),
        .status      (m_axis_tuser)
    );

endmodule
